// File: rtl/core/hts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package hts_pkg;

  localparam int unsigned TimerWidthDefault = 24;
  localparam int unsigned HalfPeriodWidth   = 24;
  localparam int unsigned CmdWidth          = 8;
  localparam int unsigned CfgIndexWidth     = 2;
  localparam int unsigned CfgDataWidth      = 24;
  localparam int unsigned TempWidth         = 15;
  localparam int unsigned HumWidth          = 14;
  localparam int unsigned RawWidth          = 16;

  localparam logic [CfgIndexWidth-1:0] RegHalfPeriod = 2'd0;
  localparam logic [CfgIndexWidth-1:0] RegTempCmd    = 2'd1;
  localparam logic [CfgIndexWidth-1:0] RegHumCmd     = 2'd2;

  localparam logic [HalfPeriodWidth-1:0] HalfPeriodReset = 24'd1000;
  localparam logic [CmdWidth-1:0]        TempCmdReset    = 8'd3;
  localparam logic [CmdWidth-1:0]        HumCmdReset     = 8'd5;

  // conversion constants, Q32
  localparam int unsigned AccWidth = 60;
  localparam logic signed [AccWidth-1:0] KC1 = -60'sd879093906145;
  localparam logic signed [40:0]         KC2 = 41'sd15762529976;
  localparam logic signed [20:0]         KC3 = -21'sd685262;
  localparam logic signed [27:0]         KT1 = 28'sd42949673;
  localparam logic signed [20:0]         KT2 = 21'sd343597;
  localparam logic signed [AccWidth-1:0] HumMaxQ = 60'sd42949672960000;
  localparam logic signed [16:0] TempOffset = 17'sd3960;
  localparam logic signed [17:0] TempRef    = 18'sd2500;
  localparam logic signed [16:0] TempHigh   = 17'sd12380;
  localparam logic signed [16:0] TempLow    = -17'sd4000;

  typedef enum logic [4:0] {
    PH_IDLE, PH_S0, PH_S1, PH_S2, PH_S3, PH_S4, PH_S5, PH_B0, PH_B1,
    PH_A0, PH_A1, PH_A2, PH_W, PH_R1, PH_R2, PH_R3, PH_K0, PH_K1, PH_K2,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {DS_KEEP, DS_ZERO, DS_ONE, DS_CMD} data_sel_t;

  typedef struct packed {
    logic      set_lines;
    logic      line_c;
    data_sel_t d_sel;
    logic      line_drv;
    logic      pause;
    logic      bc_load8;
    logic      bc_dec;
    logic      bc_inc;
    logic      bc_clr;
    logic      byc_inc;
    logic      byc_clr;
    logic      sh_clr;
    logic      sh_shift;
    logic      raw_load;
    logic      mh_set;
    logic      mh_clr;
    logic      conv_start;
  } hts_cmd_t;

  typedef struct packed {
    logic       timer_zero;
    logic [3:0] bit_count;
    logic [1:0] byte_count;
    logic       mh;
  } hts_status_t;

  typedef struct packed {
    logic c;
    logic d;
    logic drv;
  } hts_lines_t;

endpackage
`default_nettype wire

// File: rtl/core/hts_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface hts_in_if;
  logic valid;
  logic ready;
  logic start_request;
  logic sda_in;
  modport source (output valid, start_request, sda_in, input ready);
  modport sink (input valid, start_request, sda_in, output ready);
endinterface

interface hts_out_if;
  logic valid;
  logic ready;
  logic scl;
  logic sda_out;
  logic sda_drive;
  logic busy_res;
  logic result_valid;
  logic signed [14:0] temperature_centi;
  logic [13:0] humidity_centi;
  logic out_of_range;
  modport source (output valid, scl, sda_out, sda_drive, busy_res, result_valid,
                  temperature_centi, humidity_centi, out_of_range, input ready);
  modport sink (input valid, scl, sda_out, sda_drive, busy_res, result_valid,
                temperature_centi, humidity_centi, out_of_range, output ready);
endinterface
`default_nettype wire

// File: rtl/core/hts_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module hts_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 step,
  input  wire logic                 start_request,
  input  wire logic                 sda_in,
  input  wire hts_pkg::hts_status_t status,
  output hts_pkg::hts_cmd_t         cmd,
  output logic                      busy_next
);

  hts_pkg::phase_t phase, phase_next;
  logic act;

  assign act = step && status.timer_zero;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= hts_pkg::PH_IDLE;
    end else begin
      phase <= phase_next;
    end
  end

  always_comb begin
    phase_next = phase;
    if (act) begin
      case (phase)
        hts_pkg::PH_IDLE: if (start_request) phase_next = hts_pkg::PH_S0;
        hts_pkg::PH_S0: phase_next = hts_pkg::PH_S1;
        hts_pkg::PH_S1: phase_next = hts_pkg::PH_S2;
        hts_pkg::PH_S2: phase_next = hts_pkg::PH_S3;
        hts_pkg::PH_S3: phase_next = hts_pkg::PH_S4;
        hts_pkg::PH_S4: phase_next = hts_pkg::PH_S5;
        hts_pkg::PH_S5: phase_next = hts_pkg::PH_B0;
        hts_pkg::PH_B0: phase_next = hts_pkg::PH_B1;
        hts_pkg::PH_B1:
          phase_next = (status.bit_count != 4'd1) ? hts_pkg::PH_B0 : hts_pkg::PH_A0;
        hts_pkg::PH_A0: phase_next = hts_pkg::PH_A1;
        hts_pkg::PH_A1: if (!sda_in) phase_next = hts_pkg::PH_A2;
        hts_pkg::PH_A2: phase_next = hts_pkg::PH_W;
        hts_pkg::PH_W:  if (!sda_in) phase_next = hts_pkg::PH_R1;
        hts_pkg::PH_R1: phase_next = hts_pkg::PH_R2;
        hts_pkg::PH_R2: phase_next = hts_pkg::PH_R3;
        hts_pkg::PH_R3:
          phase_next = ((status.bit_count + 4'd1) < 4'd8) ? hts_pkg::PH_R1
                                                         : hts_pkg::PH_K0;
        hts_pkg::PH_K0: phase_next = hts_pkg::PH_K1;
        hts_pkg::PH_K1: phase_next = hts_pkg::PH_K2;
        hts_pkg::PH_K2:
          phase_next = (status.byte_count != 2'd2) ? hts_pkg::PH_R1 : hts_pkg::PH_DONE;
        hts_pkg::PH_DONE:
          phase_next = status.mh ? hts_pkg::PH_IDLE : hts_pkg::PH_S0;
        default: phase_next = hts_pkg::PH_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd = '0;
    cmd.d_sel = hts_pkg::DS_KEEP;
    if (act) begin
      case (phase)
        hts_pkg::PH_IDLE: cmd.mh_clr = start_request;
        hts_pkg::PH_S0: begin
          cmd.set_lines = 1'b1; cmd.line_c = 1'b1; cmd.d_sel = hts_pkg::DS_ONE;
          cmd.line_drv = 1'b1; cmd.pause = 1'b1;
        end
        hts_pkg::PH_S1, hts_pkg::PH_S3: begin
          cmd.set_lines = 1'b1; cmd.line_c = 1'b1; cmd.d_sel = hts_pkg::DS_ZERO;
          cmd.line_drv = 1'b1; cmd.pause = 1'b1;
        end
        hts_pkg::PH_S2: begin
          cmd.set_lines = 1'b1; cmd.d_sel = hts_pkg::DS_ZERO;
          cmd.line_drv = 1'b1; cmd.pause = 1'b1;
        end
        hts_pkg::PH_S4: begin
          cmd.set_lines = 1'b1; cmd.line_c = 1'b1; cmd.d_sel = hts_pkg::DS_ONE;
          cmd.line_drv = 1'b1; cmd.pause = 1'b1;
        end
        hts_pkg::PH_S5: begin
          cmd.set_lines = 1'b1; cmd.d_sel = hts_pkg::DS_ONE;
          cmd.line_drv = 1'b1; cmd.pause = 1'b1; cmd.bc_load8 = 1'b1;
        end
        hts_pkg::PH_B0: begin
          cmd.set_lines = 1'b1; cmd.line_drv = 1'b1; cmd.pause = 1'b1;
        end
        hts_pkg::PH_B1: begin
          cmd.set_lines = 1'b1; cmd.line_c = 1'b1; cmd.d_sel = hts_pkg::DS_CMD;
          cmd.line_drv = 1'b1; cmd.pause = 1'b1; cmd.bc_dec = 1'b1;
        end
        hts_pkg::PH_A0: cmd.set_lines = 1'b1;
        hts_pkg::PH_A1: if (!sda_in) begin
          cmd.set_lines = 1'b1; cmd.line_c = 1'b1; cmd.pause = 1'b1;
        end
        hts_pkg::PH_A2: begin
          cmd.set_lines = 1'b1; cmd.pause = 1'b1;
        end
        hts_pkg::PH_W: if (!sda_in) begin
          cmd.byc_clr = 1'b1; cmd.bc_clr = 1'b1; cmd.sh_clr = 1'b1;
        end
        hts_pkg::PH_R1: begin
          cmd.set_lines = 1'b1; cmd.pause = 1'b1;
        end
        hts_pkg::PH_R2: begin
          cmd.set_lines = 1'b1; cmd.line_c = 1'b1; cmd.pause = 1'b1;
        end
        hts_pkg::PH_R3: begin
          cmd.sh_shift = 1'b1; cmd.bc_inc = 1'b1;
        end
        hts_pkg::PH_K0: begin
          cmd.raw_load = 1'b1; cmd.set_lines = 1'b1; cmd.d_sel = hts_pkg::DS_ZERO;
          cmd.line_drv = 1'b1;
        end
        hts_pkg::PH_K1: begin
          cmd.set_lines = 1'b1; cmd.line_c = 1'b1; cmd.d_sel = hts_pkg::DS_ZERO;
          cmd.line_drv = 1'b1; cmd.pause = 1'b1;
        end
        hts_pkg::PH_K2: begin
          cmd.set_lines = 1'b1; cmd.d_sel = hts_pkg::DS_ZERO; cmd.line_drv = 1'b1;
          cmd.pause = 1'b1; cmd.byc_inc = 1'b1; cmd.bc_clr = 1'b1; cmd.sh_clr = 1'b1;
        end
        hts_pkg::PH_DONE: begin
          cmd.mh_set = !status.mh;
          cmd.conv_start = status.mh;
        end
        default: cmd.set_lines = 1'b0;
      endcase
    end
  end

  assign busy_next = (phase_next != hts_pkg::PH_IDLE);

endmodule
`default_nettype wire

// File: rtl/core/hts_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module hts_dp #(
  parameter int unsigned TIMER_WIDTH = hts_pkg::TimerWidthDefault
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  step,
  input  wire logic                                  sda_in,
  input  wire hts_pkg::hts_cmd_t                     cmd,
  input  wire logic                                  cfg_we,
  input  wire logic [hts_pkg::CfgIndexWidth-1:0]     cfg_index,
  input  wire logic [hts_pkg::CfgDataWidth-1:0]      cfg_data,
  output hts_pkg::hts_status_t                       status,
  output hts_pkg::hts_lines_t                        lines,
  output hts_pkg::hts_lines_t                        lines_next,
  output logic [hts_pkg::RawWidth-1:0]               raw_temperature,
  output logic [hts_pkg::RawWidth-1:0]               raw_humidity
);

  logic [hts_pkg::HalfPeriodWidth-1:0] half_period_ticks;
  logic [hts_pkg::CmdWidth-1:0]        temp_command;
  logic [hts_pkg::CmdWidth-1:0]        humidity_command;
  logic [TIMER_WIDTH-1:0]              pause_timer;
  logic [3:0]                          bit_count;
  logic [1:0]                          byte_count;
  logic [7:0]                          shift_byte;
  logic                                mh;
  logic [7:0]                          cmd_byte;
  logic [3:0]                          bit_sel;
  logic                                d_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period_ticks <= hts_pkg::HalfPeriodReset;
      temp_command      <= hts_pkg::TempCmdReset;
      humidity_command  <= hts_pkg::HumCmdReset;
    end else if (cfg_we) begin
      case (cfg_index)
        hts_pkg::RegHalfPeriod: half_period_ticks <= cfg_data;
        hts_pkg::RegTempCmd:    temp_command <= cfg_data[hts_pkg::CmdWidth-1:0];
        hts_pkg::RegHumCmd:     humidity_command <= cfg_data[hts_pkg::CmdWidth-1:0];
        default: ;
      endcase
    end
  end

  assign cmd_byte = mh ? humidity_command : temp_command;
  assign bit_sel  = bit_count - 4'd1;

  always_comb begin
    case (cmd.d_sel)
      hts_pkg::DS_ZERO: d_next = 1'b0;
      hts_pkg::DS_ONE:  d_next = 1'b1;
      hts_pkg::DS_CMD:  d_next = cmd_byte[bit_sel[2:0]];
      default:          d_next = lines.d;
    endcase
    lines_next = lines;
    if (cmd.set_lines) begin
      lines_next.c   = cmd.line_c;
      lines_next.d   = d_next;
      lines_next.drv = cmd.line_drv;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pause_timer     <= '0;
      bit_count       <= '0;
      byte_count      <= '0;
      shift_byte      <= '0;
      mh              <= 1'b0;
      raw_temperature <= '0;
      raw_humidity    <= '0;
      lines           <= '{c: 1'b0, d: 1'b1, drv: 1'b1};
    end else if (step) begin
      lines <= lines_next;
      if (pause_timer != '0) begin
        pause_timer <= pause_timer - 1'b1;
      end else if (cmd.pause) begin
        pause_timer <= TIMER_WIDTH'(half_period_ticks);
      end
      if (cmd.bc_load8) bit_count <= 4'd8;
      if (cmd.bc_dec)   bit_count <= bit_count - 4'd1;
      if (cmd.bc_inc)   bit_count <= bit_count + 4'd1;
      if (cmd.bc_clr)   bit_count <= '0;
      if (cmd.byc_inc)  byte_count <= byte_count + 2'd1;
      if (cmd.byc_clr)  byte_count <= '0;
      if (cmd.sh_shift) shift_byte <= {shift_byte[6:0], sda_in};
      if (cmd.sh_clr)   shift_byte <= '0;
      if (cmd.mh_set)   mh <= 1'b1;
      if (cmd.mh_clr)   mh <= 1'b0;
      if (cmd.raw_load) begin
        if (byte_count == 2'd0) begin
          if (mh) raw_humidity <= {shift_byte, 8'd0};
          else    raw_temperature <= {shift_byte, 8'd0};
        end else if (byte_count == 2'd1) begin
          if (mh) raw_humidity <= {raw_humidity[15:8], shift_byte};
          else    raw_temperature <= {raw_temperature[15:8], shift_byte};
        end
      end
    end
  end

  assign status.timer_zero = (pause_timer == '0);
  assign status.bit_count  = bit_count;
  assign status.byte_count = byte_count;
  assign status.mh         = mh;

endmodule
`default_nettype wire

// File: rtl/core/hts_conv.sv
`timescale 1ns / 1ps
`default_nettype none
module hts_conv (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               start,
  input  wire logic [hts_pkg::RawWidth-1:0]       raw_temperature,
  input  wire logic [hts_pkg::RawWidth-1:0]       raw_humidity,
  output logic                                    busy,
  output logic                                    done,
  output logic signed [hts_pkg::TempWidth-1:0]    temperature_centi,
  output logic [hts_pkg::HumWidth-1:0]            humidity_centi,
  output logic                                    out_of_range
);

  localparam logic [4:0] StepSum  = 5'd1;
  localparam logic [4:0] StepLast = 5'd18;
  localparam int unsigned AW = hts_pkg::AccWidth;

  logic [4:0]              cnt;
  logic signed [16:0]      tc;
  logic signed [17:0]      dt;
  logic signed [16:0]      rh_s;
  logic signed [38:0]      p1;
  logic signed [37:0]      p2;
  logic signed [45:0]      p3;
  logic signed [AW-1:0]    a_sh;
  logic signed [AW-1:0]    acc;
  logic [15:0]             rh_sh;
  logic                    bad;

  assign tc   = $signed({1'b0, raw_temperature}) - hts_pkg::TempOffset;
  assign dt   = 18'(tc) - hts_pkg::TempRef;
  assign rh_s = $signed({1'b0, raw_humidity});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 5'd1;
      if (cnt == StepLast) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      if (cnt == 5'd0) begin
        p1 <= dt * hts_pkg::KT2;
        p2 <= rh_s * hts_pkg::KC3;
        p3 <= dt * hts_pkg::KT1;
      end else if (cnt == StepSum) begin
        a_sh  <= AW'(hts_pkg::KC2) + AW'(p1) + AW'(p2);
        acc   <= hts_pkg::KC1 + AW'(p3);
        rh_sh <= raw_humidity;
      end else if (cnt != StepLast) begin
        if (rh_sh[0]) acc <= acc + a_sh;
        a_sh  <= a_sh <<< 1;
        rh_sh <= rh_sh >> 1;
      end
    end
  end

  assign done = busy && (cnt == StepLast);
  assign bad  = (tc > hts_pkg::TempHigh) || (tc < hts_pkg::TempLow) ||
                (acc < 0) || (acc > hts_pkg::HumMaxQ);
  assign out_of_range      = bad;
  assign temperature_centi = bad ? '0 : tc[hts_pkg::TempWidth-1:0];
  assign humidity_centi    = bad ? '0 : acc[32 +: hts_pkg::HumWidth];

endmodule
`default_nettype wire

// File: rtl/core/humidity_temp_sensor_controller.sv
`timescale 1ns / 1ps
`default_nettype none
// Two-wire humidity/temperature sensor controller. Each transfer on meas_in is one
// line tick (start request plus sampled data line) and yields one transfer on
// meas_out with the line levels after that tick, busy, and the held results.
// The tick that finishes a measurement cycle is answered by the shift-add
// conversion unit (one humidity bit per cycle); no tick is accepted while it
// runs, nor while the output register holds a transfer that is not taken.
// Configuration is a plain write port: index 0 half period, 1 temperature
// command, 2 humidity command; other indexes are ignored.
module humidity_temp_sensor_controller #(
  parameter int unsigned TIMER_WIDTH = hts_pkg::TimerWidthDefault
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [hts_pkg::CfgIndexWidth-1:0]  cfg_index,
  input  wire logic [hts_pkg::CfgDataWidth-1:0]   cfg_data,
  hts_in_if.sink                                  meas_in,
  hts_out_if.source                               meas_out
);

  hts_pkg::hts_cmd_t    cmd;
  hts_pkg::hts_status_t status;
  hts_pkg::hts_lines_t  lines, lines_next;
  logic [hts_pkg::RawWidth-1:0] raw_temperature, raw_humidity;
  logic busy_next, step, conv_busy, conv_done, conv_bad;
  logic signed [hts_pkg::TempWidth-1:0] conv_t, held_t;
  logic [hts_pkg::HumWidth-1:0] conv_h, held_h;
  logic held_bad, out_valid;

  assign meas_in.ready = !conv_busy && (!out_valid || meas_out.ready);
  assign step = meas_in.valid && meas_in.ready;

  hts_ctrl u_ctrl (
    .clk, .rst, .step,
    .start_request(meas_in.start_request),
    .sda_in(meas_in.sda_in),
    .status, .cmd, .busy_next
  );

  hts_dp #(.TIMER_WIDTH(TIMER_WIDTH)) u_dp (
    .clk, .rst, .step,
    .sda_in(meas_in.sda_in),
    .cmd, .cfg_we, .cfg_index, .cfg_data,
    .status, .lines, .lines_next, .raw_temperature, .raw_humidity
  );

  hts_conv u_conv (
    .clk, .rst,
    .start(cmd.conv_start),
    .raw_temperature, .raw_humidity,
    .busy(conv_busy), .done(conv_done),
    .temperature_centi(conv_t), .humidity_centi(conv_h), .out_of_range(conv_bad)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      held_t    <= '0;
      held_h    <= '0;
      held_bad  <= 1'b0;
    end else begin
      if (conv_done || (step && !cmd.conv_start)) begin
        out_valid <= 1'b1;
      end else if (meas_out.valid && meas_out.ready) begin
        out_valid <= 1'b0;
      end
      if (conv_done) begin
        held_t       <= conv_t;
        held_h       <= conv_h;
        held_bad     <= conv_bad;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (conv_done) begin
      meas_out.scl               <= lines.c;
      meas_out.sda_out           <= lines.d;
      meas_out.sda_drive         <= lines.drv;
      meas_out.busy_res          <= 1'b0;
      meas_out.result_valid      <= 1'b1;
      meas_out.temperature_centi <= conv_t;
      meas_out.humidity_centi    <= conv_h;
      meas_out.out_of_range      <= conv_bad;
    end else if (step) begin
      meas_out.scl               <= lines_next.c;
      meas_out.sda_out           <= lines_next.d;
      meas_out.sda_drive         <= lines_next.drv;
      meas_out.busy_res          <= busy_next;
      meas_out.result_valid      <= 1'b0;
      meas_out.temperature_centi <= held_t;
      meas_out.humidity_centi    <= held_h;
      meas_out.out_of_range      <= held_bad;
    end
  end

  assign meas_out.valid = out_valid;

endmodule
`default_nettype wire

// File: tb/tb_humidity_temp_sensor_controller.sv
`timescale 1ns / 1ps
module tb_humidity_temp_sensor_controller;
  import hts_pkg::*;

  localparam logic [CfgIndexWidth-1:0] RegUnused = 2'd3;
  localparam int WatchdogLimit = 5000;
  localparam int DrainCycles = 60;

  typedef struct {
    logic [23:0] half_period;
    logic [7:0]  t_cmd;
    logic [7:0]  h_cmd;
    phase_t      ph;
    logic [23:0] tmr;
    logic [3:0]  bits;
    logic [1:0]  bytes;
    logic [7:0]  shreg;
    logic        hum_pass;
    logic [15:0] raw_t;
    logic [15:0] raw_h;
    logic        c, d, drv;
    logic signed [14:0] t_out;
    logic [13:0] h_out;
    logic        bad;
  } sensor_state_t;

  typedef struct packed {
    logic c, d, drv, busy, rv;
    logic signed [14:0] t_out;
    logic [13:0] h_out;
    logic bad;
  } tick_out_t;

  typedef struct packed {
    logic start;
    logic sda;
  } tick_in_t;

  logic clk, rst;
  logic cfg_we;
  logic [CfgIndexWidth-1:0] cfg_index;
  logic [CfgDataWidth-1:0] cfg_data;

  hts_in_if  in_if();
  hts_out_if out_if();

  humidity_temp_sensor_controller dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .meas_in(in_if), .meas_out(out_if)
  );

  sensor_state_t gen_st, chk_st;
  tick_in_t pending_ticks[$];
  tick_out_t expected_ticks[$];
  bit failed;
  int n_in, n_out, idle_cycles, hold_left;
  bit held;

  function automatic void sensor_reset(inout sensor_state_t m);
    m.half_period = HalfPeriodReset;
    m.t_cmd = TempCmdReset;
    m.h_cmd = HumCmdReset;
    m.ph = PH_IDLE;
    m.tmr = '0;
    m.bits = '0;
    m.bytes = '0;
    m.shreg = '0;
    m.hum_pass = 1'b0;
    m.raw_t = '0;
    m.raw_h = '0;
    m.c = 1'b0;
    m.d = 1'b1;
    m.drv = 1'b1;
    m.t_out = '0;
    m.h_out = '0;
    m.bad = 1'b0;
  endfunction

  function automatic void sensor_cfg(inout sensor_state_t m, input logic [1:0] idx,
                                     input logic [23:0] val);
    case (idx)
      RegHalfPeriod: m.half_period = val;
      RegTempCmd: m.t_cmd = val[7:0];
      RegHumCmd: m.h_cmd = val[7:0];
      default: ;
    endcase
  endfunction

  function automatic void convert_readings(inout sensor_state_t m);
    longint tc, r, acc;
    bit bad;
    tc = longint'(m.raw_t) - longint'(TempOffset);
    r = longint'(m.raw_h);
    acc = longint'(KC1) + longint'(KC2) * r + longint'(KC3) * r * r
        + (tc - longint'(TempRef)) * (longint'(KT1) + longint'(KT2) * r);
    bad = tc > longint'(TempHigh) || tc < longint'(TempLow) || acc < 0
        || acc > longint'(HumMaxQ);
    m.bad = bad;
    m.t_out = bad ? '0 : tc[14:0];
    m.h_out = bad ? '0 : acc[45:32];
  endfunction

  function automatic tick_out_t sensor_tick(inout sensor_state_t m, input tick_in_t x);
    tick_out_t o;
    logic [7:0] cmd;
    logic rv;
    rv = 1'b0;
    if (m.tmr != 0) begin
      m.tmr = m.tmr - 1'b1;
    end else begin
      case (m.ph)
        PH_IDLE: if (x.start) begin
          m.hum_pass = 1'b0;
          m.ph = PH_S0;
        end
        PH_S0: begin m.c = 1; m.d = 1; m.drv = 1; m.tmr = m.half_period; m.ph = PH_S1; end
        PH_S1: begin m.c = 1; m.d = 0; m.drv = 1; m.tmr = m.half_period; m.ph = PH_S2; end
        PH_S2: begin m.c = 0; m.d = 0; m.drv = 1; m.tmr = m.half_period; m.ph = PH_S3; end
        PH_S3: begin m.c = 1; m.d = 0; m.drv = 1; m.tmr = m.half_period; m.ph = PH_S4; end
        PH_S4: begin m.c = 1; m.d = 1; m.drv = 1; m.tmr = m.half_period; m.ph = PH_S5; end
        PH_S5: begin
          m.c = 0; m.d = 1; m.drv = 1; m.tmr = m.half_period;
          m.bits = 4'd8;
          m.ph = PH_B0;
        end
        PH_B0: begin m.c = 0; m.drv = 1; m.tmr = m.half_period; m.ph = PH_B1; end
        PH_B1: begin
          cmd = m.hum_pass ? m.h_cmd : m.t_cmd;
          m.c = 1;
          m.d = cmd[3'(m.bits - 1'b1)];
          m.drv = 1;
          m.tmr = m.half_period;
          m.bits = m.bits - 1'b1;
          m.ph = (m.bits != 0) ? PH_B0 : PH_A0;
        end
        PH_A0: begin m.c = 0; m.drv = 0; m.ph = PH_A1; end
        PH_A1: if (!x.sda) begin
          m.c = 1; m.drv = 0; m.tmr = m.half_period; m.ph = PH_A2;
        end
        PH_A2: begin m.c = 0; m.drv = 0; m.tmr = m.half_period; m.ph = PH_W; end
        PH_W: if (!x.sda) begin
          m.bytes = 0; m.bits = 0; m.shreg = 0; m.ph = PH_R1;
        end
        PH_R1: begin m.c = 0; m.drv = 0; m.tmr = m.half_period; m.ph = PH_R2; end
        PH_R2: begin m.c = 1; m.drv = 0; m.tmr = m.half_period; m.ph = PH_R3; end
        PH_R3: begin
          m.shreg = {m.shreg[6:0], x.sda};
          m.bits = m.bits + 1'b1;
          m.ph = (m.bits < 8) ? PH_R1 : PH_K0;
        end
        PH_K0: begin
          if (m.bytes == 0) begin
            if (m.hum_pass) m.raw_h = {m.shreg, 8'h00};
            else m.raw_t = {m.shreg, 8'h00};
          end else if (m.bytes == 1) begin
            if (m.hum_pass) m.raw_h[7:0] = m.shreg;
            else m.raw_t[7:0] = m.shreg;
          end
          m.c = 0; m.d = 0; m.drv = 1;
          m.ph = PH_K1;
        end
        PH_K1: begin m.c = 1; m.d = 0; m.drv = 1; m.tmr = m.half_period; m.ph = PH_K2; end
        PH_K2: begin
          m.c = 0; m.d = 0; m.drv = 1; m.tmr = m.half_period;
          m.bytes = m.bytes + 1'b1;
          m.bits = 0;
          m.shreg = 0;
          m.ph = (m.bytes < 3) ? PH_R1 : PH_DONE;
        end
        PH_DONE: begin
          if (!m.hum_pass) begin
            m.hum_pass = 1'b1;
            m.ph = PH_S0;
          end else begin
            convert_readings(m);
            rv = 1'b1;
            m.ph = PH_IDLE;
          end
        end
        default: m.ph = PH_IDLE;
      endcase
    end
    o.c = m.c;
    o.d = m.d;
    o.drv = m.drv;
    o.busy = (m.ph != PH_IDLE);
    o.rv = rv;
    o.t_out = m.t_out;
    o.h_out = m.h_out;
    o.bad = m.bad;
    return o;
  endfunction

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_if.valid <= 1'b0;
      in_if.start_request <= 1'b0;
      in_if.sda_in <= 1'b1;
      n_in <= 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        expected_ticks.push_back(sensor_tick(chk_st, '{in_if.start_request, in_if.sda_in}));
        n_in <= n_in + 1;
      end
      if (!in_if.valid || in_if.ready) begin
        if (pending_ticks.size() != 0 &&
            ((n_in > 500 && n_in < 1100) || $urandom_range(0, 99) >= 13)) begin
          tick_in_t nx;
          nx = pending_ticks.pop_front();
          in_if.valid <= 1'b1;
          in_if.start_request <= nx.start;
          in_if.sda_in <= nx.sda;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input longint exp_v, input longint act_v);
    if (exp_v != act_v) begin
      $display("%0t: mismatch %s expected %0d actual %0d", $time, name, exp_v, act_v);
      failed = 1'b1;
    end
  endtask

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      out_if.ready <= 1'b0;
      n_out <= 0;
      hold_left <= 0;
      held <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        n_out <= n_out + 1;
        if (expected_ticks.size() == 0) begin
          $display("%0t: unexpected transfer, expected none actual scl=%0b sda=%0b",
                   $time, out_if.scl, out_if.sda_out);
          failed = 1'b1;
        end else begin
          tick_out_t e;
          e = expected_ticks.pop_front();
          check_field("scl", e.c, out_if.scl);
          check_field("sda_out", e.d, out_if.sda_out);
          check_field("sda_drive", e.drv, out_if.sda_drive);
          check_field("busy_res", e.busy, out_if.busy_res);
          check_field("result_valid", e.rv, out_if.result_valid);
          check_field("temperature_centi", e.t_out, out_if.temperature_centi);
          check_field("humidity_centi", e.h_out, out_if.humidity_centi);
          check_field("out_of_range", e.bad, out_if.out_of_range);
        end
      end
      if (!held && n_out == 300) begin
        held <= 1'b1;
        hold_left <= 300;
        out_if.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= (n_out > 700 && n_out < 1300) || $urandom_range(0, 99) >= 13;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic push_tick(input logic start, input logic sda);
    tick_out_t unused;
    while (pending_ticks.size() > 16) @(posedge clk);
    pending_ticks.push_back('{start, sda});
    unused = sensor_tick(gen_st, '{start, sda});
  endtask

  task automatic wait_drained();
    while (pending_ticks.size() != 0 || in_if.valid || expected_ticks.size() != 0)
      @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [23:0] val);
    wait_drained();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    sensor_cfg(gen_st, idx, val);
    sensor_cfg(chk_st, idx, val);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // one full measurement; sensor answers with the given words unless noisy
  task automatic run_measurement(input logic [15:0] t_word, input logic [15:0] h_word,
                                 input bit noisy);
    logic sda;
    logic [15:0] w;
    push_tick(1'b1, 1'($urandom));
    while (gen_st.ph != PH_IDLE || gen_st.tmr != 0) begin
      sda = 1'($urandom);
      if (gen_st.tmr == 0 && !noisy) begin
        w = gen_st.hum_pass ? h_word : t_word;
        case (gen_st.ph)
          PH_A1, PH_W: sda = ($urandom_range(0, 3) == 0);
          PH_R3: begin
            if (gen_st.bytes == 0) sda = w[4'd15 - 4'(gen_st.bits)];
            else if (gen_st.bytes == 1) sda = w[4'd7 - 4'(gen_st.bits)];
          end
          default: ;
        endcase
      end else if (gen_st.tmr == 0 && (gen_st.ph == PH_A1 || gen_st.ph == PH_W)) begin
        sda = ($urandom_range(0, 1) == 0);
      end
      push_tick(1'($urandom), sda);
    end
  endtask

  function automatic logic [15:0] pick_word(input bit is_temp);
    case ($urandom_range(0, 5))
      0: return 16'(is_temp ? $urandom_range(0, 16340) : $urandom_range(0, 4095));
      1: return is_temp ? 16'(16340 + $urandom_range(0, 2)) : 16'($urandom_range(0, 100));
      2: return 16'($urandom_range(0, 1) ? 16'hFFFF : 16'h0000);
      default: return 16'(is_temp ? $urandom_range(3000, 9000) : $urandom_range(300, 3500));
    endcase
  endfunction

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    failed = 1'b0;
    sensor_reset(gen_st);
    sensor_reset(chk_st);
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    repeat (4) push_tick(1'b0, 1'($urandom));
    cfg_write(RegHalfPeriod, 24'hFFFFFF);
    cfg_write(RegUnused, 24'hFFFFFF);
    repeat (3) push_tick(1'b0, 1'($urandom));
    cfg_write(RegHalfPeriod, 24'd1);
    cfg_write(RegTempCmd, 8'h00);
    cfg_write(RegHumCmd, 8'hFF);
    run_measurement(16'd16340, 16'd1500, 1'b0);
    cfg_write(RegTempCmd, 8'hFF);
    cfg_write(RegHumCmd, 8'h00);
    run_measurement(16'd16341, 16'hFFFF, 1'b0);

    while (n_in + pending_ticks.size() < 1100) begin
      cfg_write(RegHalfPeriod, 24'($urandom_range(1, 3)));
      cfg_write(RegTempCmd, 8'($urandom));
      cfg_write(RegHumCmd, 8'($urandom));
      repeat ($urandom_range(0, 3)) push_tick(1'b0, 1'($urandom));
      run_measurement(pick_word(1'b1), pick_word(1'b0), $urandom_range(0, 9) == 0);
    end

    wait_drained();
    repeat (DrainCycles) @(posedge clk);
    if (!failed) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
